// ===== src/hidkd_pkg.sv =====
// ----------------------------------------------------------------------------
// hidkd_pkg
// Shared constants, types and the usage-to-key-code table for the report differ.
// ----------------------------------------------------------------------------
`default_nettype none

package hidkd_pkg;

    localparam int KeySlots  = 6;
    localparam int InSlots   = 6;
    localparam int ModBits   = 8;
    // Events per report: modifier bits, releases, presses.
    localparam int NumEvents = ModBits + 2 * KeySlots;

    localparam logic [0:0] KindKey  = 1'b0;
    localparam logic [0:0] KindSync = 1'b1;

    localparam logic [7:0] ModUsageBase = 8'hE0;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] key_code;
        logic       pressed;
        logic       last;
    } event_t;

    function automatic logic [7:0] usage_to_key(input logic [7:0] usage);
        logic [7:0] k;
        k = 8'd0;
        case (usage)
            8'h04: k = 8'd30;  8'h05: k = 8'd48;  8'h06: k = 8'd46;  8'h07: k = 8'd32;
            8'h08: k = 8'd18;  8'h09: k = 8'd33;  8'h0A: k = 8'd34;  8'h0B: k = 8'd35;
            8'h0C: k = 8'd23;  8'h0D: k = 8'd36;  8'h0E: k = 8'd37;  8'h0F: k = 8'd38;
            8'h10: k = 8'd50;  8'h11: k = 8'd49;  8'h12: k = 8'd24;  8'h13: k = 8'd25;
            8'h14: k = 8'd16;  8'h15: k = 8'd19;  8'h16: k = 8'd31;  8'h17: k = 8'd20;
            8'h18: k = 8'd22;  8'h19: k = 8'd47;  8'h1A: k = 8'd17;  8'h1B: k = 8'd45;
            8'h1C: k = 8'd21;  8'h1D: k = 8'd44;  8'h1E: k = 8'd2;   8'h1F: k = 8'd3;
            8'h20: k = 8'd4;   8'h21: k = 8'd5;   8'h22: k = 8'd6;   8'h23: k = 8'd7;
            8'h24: k = 8'd8;   8'h25: k = 8'd9;   8'h26: k = 8'd10;  8'h27: k = 8'd11;
            8'h28: k = 8'd28;  8'h29: k = 8'd1;   8'h2A: k = 8'd14;  8'h2B: k = 8'd15;
            8'h2C: k = 8'd57;  8'h2D: k = 8'd12;  8'h2E: k = 8'd13;  8'h2F: k = 8'd26;
            8'h30: k = 8'd27;  8'h31: k = 8'd43;  8'h33: k = 8'd39;  8'h34: k = 8'd40;
            8'h35: k = 8'd41;  8'h36: k = 8'd51;  8'h37: k = 8'd52;  8'h38: k = 8'd53;
            8'h39: k = 8'd58;  8'h3A: k = 8'd59;  8'h3B: k = 8'd60;  8'h3C: k = 8'd61;
            8'h3D: k = 8'd62;  8'h3E: k = 8'd63;  8'h3F: k = 8'd64;  8'h40: k = 8'd65;
            8'h41: k = 8'd66;  8'h42: k = 8'd67;  8'h43: k = 8'd68;  8'h44: k = 8'd87;
            8'h45: k = 8'd88;  8'h46: k = 8'd99;  8'h47: k = 8'd70;  8'h48: k = 8'd119;
            8'h49: k = 8'd110; 8'h4A: k = 8'd102; 8'h4B: k = 8'd104; 8'h4C: k = 8'd111;
            8'h4D: k = 8'd107; 8'h4E: k = 8'd109; 8'h4F: k = 8'd106; 8'h50: k = 8'd105;
            8'h51: k = 8'd108; 8'h52: k = 8'd103; 8'h53: k = 8'd69;  8'h54: k = 8'd98;
            8'h55: k = 8'd55;  8'h56: k = 8'd74;  8'h57: k = 8'd78;  8'h58: k = 8'd96;
            8'h59: k = 8'd79;  8'h5A: k = 8'd80;  8'h5B: k = 8'd81;  8'h5C: k = 8'd75;
            8'h5D: k = 8'd76;  8'h5E: k = 8'd77;  8'h5F: k = 8'd71;  8'h60: k = 8'd72;
            8'h61: k = 8'd73;  8'h62: k = 8'd82;  8'h63: k = 8'd83;  8'h64: k = 8'd86;
            8'h65: k = 8'd127;
            8'hE0: k = 8'd29;  8'hE1: k = 8'd42;  8'hE2: k = 8'd56;  8'hE3: k = 8'd125;
            8'hE4: k = 8'd97;  8'hE5: k = 8'd54;  8'hE6: k = 8'd100; 8'hE7: k = 8'd126;
            default: k = 8'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== src/hid_report_diff_to_key_events.sv =====
// ----------------------------------------------------------------------------
// hid_report_diff_to_key_events
// Turns boot-keyboard reports into a serial stream of key events.
// ----------------------------------------------------------------------------
// Each request on the slave channel is one report: a modifier byte and six
// usage slots. The report is compared with the previous one in a single
// registered pass, giving a vector of up to twenty candidate events (eight
// modifier bits, six releases, six presses) with a valid mask. The report
// then becomes the previous report and the event vector is held in a work
// register, from which an emitter sends one event per cycle in order while
// the receiver does not stall, skipping masked entries, and closes the run
// with a sync item (tlast high). A run therefore holds one to twenty-one
// items on the master channel, paced by the emitter. Each event passes from
// the work register through the output register. A new report is accepted
// while the final item of the current run is being sent, so runs follow
// back to back. When the receiver stalls, the output register holds its
// request and the emitter waits; nothing is lost. Reset clears the previous
// report to all zero, empties the work register and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_diff_to_key_events (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // modifier_bits[7:0], slot_key_0..slot_key_5 upwards in bytes.
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // key_code[7:0], pressed[8], zero pad [15:9].
    output logic [15:0]      m_axis_tdata,
    // event_kind.
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int N = hidkd_pkg::NumEvents;
    localparam int K = hidkd_pkg::KeySlots;

    logic [7:0]       prev_slots_reg [K];
    logic [7:0]       prev_slots_next [K];
    logic [7:0]       prev_mods_reg;

    logic             busy_reg;
    logic [N-1:0]     pend_reg, pend_next;
    logic [7:0]       code_reg [N], code_next [N];
    logic [N-1:0]     dir_reg, dir_next;

    hidkd_pkg::event_t out_reg, out_next;
    logic             ovalid_reg;

    logic [7:0]       now [K];
    logic             s_fire, slot_free;
    logic [7:0]       mods;

    // Output slot is free when empty or being taken.
    assign slot_free = !ovalid_reg || m_axis_tready;
    // A new report may enter when no run is pending, or when the emitter is
    // about to send the sync of the current run.
    assign s_axis_tready = slot_free && (pend_reg == '0);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign mods = s_axis_tdata[7:0];

    always_comb begin
        for (int i = 0; i < K; i++) begin
            now[i] = (i < hidkd_pkg::InSlots) ? s_axis_tdata[8*i+8 +: 8] : 8'd0;
        end
    end

    // Diff of the incoming report against the previous one.
    logic [N-1:0] cand_valid;
    logic [7:0]   cand_code [N];
    logic [N-1:0] cand_dir;

    always_comb begin
        logic hit;
        logic [7:0] c;
        for (int i = 0; i < hidkd_pkg::ModBits; i++) begin
            c = hidkd_pkg::usage_to_key(hidkd_pkg::ModUsageBase + 8'(i));
            cand_code[i]  = c;
            cand_dir[i]   = mods[i];
            cand_valid[i] = (mods[i] != prev_mods_reg[i]) && (c != 8'd0);
        end
        for (int i = 0; i < K; i++) begin
            hit = 1'b0;
            for (int j = 0; j < K; j++) hit = hit | (now[j] == prev_slots_reg[i]);
            c = hidkd_pkg::usage_to_key(prev_slots_reg[i]);
            cand_code[hidkd_pkg::ModBits+i]  = c;
            cand_dir[hidkd_pkg::ModBits+i]   = 1'b0;
            cand_valid[hidkd_pkg::ModBits+i] =
                (prev_slots_reg[i] != 8'd0) && !hit && (c != 8'd0);
        end
        for (int i = 0; i < K; i++) begin
            hit = 1'b0;
            for (int j = 0; j < K; j++) hit = hit | (prev_slots_reg[j] == now[i]);
            c = hidkd_pkg::usage_to_key(now[i]);
            cand_code[hidkd_pkg::ModBits+K+i]  = c;
            cand_dir[hidkd_pkg::ModBits+K+i]   = 1'b1;
            cand_valid[hidkd_pkg::ModBits+K+i] = (now[i] != 8'd0) && !hit && (c != 8'd0);
        end
    end

    // Emitter: lowest pending event first, then the sync.
    logic [N-1:0] first_oh;
    assign first_oh = pend_reg & (~pend_reg + N'(1));

    always_comb begin
        pend_next = pend_reg;
        code_next = code_reg;
        dir_next  = dir_reg;
        out_next  = out_reg;
        prev_slots_next = prev_slots_reg;
        if (slot_free && busy_reg) begin
            if (pend_reg != '0) begin
                out_next.event_kind = hidkd_pkg::KindKey;
                out_next.key_code   = 8'd0;
                out_next.pressed    = 1'b0;
                for (int i = 0; i < N; i++) begin
                    if (first_oh[i]) begin
                        out_next.key_code = code_reg[i];
                        out_next.pressed  = dir_reg[i];
                    end
                end
                out_next.last = 1'b0;
                pend_next = pend_reg & ~first_oh;
            end else begin
                out_next.event_kind = hidkd_pkg::KindSync;
                out_next.key_code   = 8'd0;
                out_next.pressed    = 1'b0;
                out_next.last       = 1'b1;
            end
        end
        if (s_fire) begin
            pend_next = cand_valid;
            code_next = cand_code;
            dir_next  = cand_dir;
            prev_slots_next = now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            ovalid_reg    <= 1'b0;
            pend_reg      <= '0;
            prev_mods_reg <= 8'd0;
            for (int i = 0; i < K; i++) prev_slots_reg[i] <= 8'd0;
        end else begin
            pend_reg       <= pend_next;
            prev_slots_reg <= prev_slots_next;
            if (s_fire) prev_mods_reg <= mods;
            if (slot_free) ovalid_reg <= busy_reg;
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (slot_free && busy_reg && pend_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
        code_reg <= code_next;
        dir_reg  <= dir_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.pressed, out_reg.key_code};
    assign m_axis_tuser  = out_reg.event_kind;
    assign m_axis_tlast  = out_reg.last;

endmodule

`default_nettype wire
